// ===== rtl/hd_pkg.sv =====
// Package for the haversine distance block: fixed-point constants, datapath
// types and the CORDIC arctangent table. Depends on nothing.
`default_nettype none

package hd_pkg;

    // Datapath width of the CORDIC lanes, signed Q3.30 with headroom.
    localparam int CW = 34;

    localparam int CORDIC_STEPS_DEF = 32;
    localparam int MAX_STEPS        = 40;

    // The square root takes a 62-bit radicand and settles one root bit a stage.
    localparam int SQRT_W     = 62;
    localparam int SQRT_STEPS = 31;

    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    // Scale from 1e-7 degree to Q2.30 radians of the halved angle, times 2^32.
    localparam logic [31:0] CONV = 32'((PI_Q61 + 64'd900000000) / 64'd1800000000);

    localparam logic signed [CW-1:0] GAIN_INV   = 34'sd652032874;
    localparam logic signed [30:0]   LAT_LIMIT  = 31'sd900000000;
    localparam logic signed [33:0]   FULL_TURN  = 34'sd3600000000;
    localparam logic signed [33:0]   HALF_TURN  = 34'sd1800000000;
    localparam logic [22:0]          RADIUS_RESET = 23'd6378137;

    typedef logic signed [CW-1:0] cval_t;

    // Arctangent of 2^-i in Q2.30; zero from step 31 on.
    function automatic cval_t atan_q30(input int i);
        cval_t v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            default:
            begin
                if (i <= 30)
                    v = cval_t'(34'sd1 <<< (30 - i));
                else
                    v = '0;
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hd_if.sv =====
// Valid/ready channel interfaces for the haversine distance block: one for
// position pairs and one for distances. No dependencies.
`default_nettype none

interface hd_pair_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface hd_dist_if;
    logic        valid;
    logic        ready;
    logic [24:0] distance_m;

    modport source (output valid, distance_m, input ready);
    modport sink   (input valid, distance_m, output ready);
endinterface

`default_nettype wire

// ===== rtl/hd_cordic.sv =====
// Pipelined CORDIC, one iteration per register stage, in rotation or
// vectoring mode. Depends on hd_pkg.
`default_nettype none

module hd_cordic
    import hd_pkg::*;
#(
    parameter int STEPS  = CORDIC_STEPS_DEF,
    parameter bit VECTOR = 1'b0
)
(
    input  wire   clk,
    input  wire   en,
    input  cval_t x_i,
    input  cval_t y_i,
    input  cval_t z_i,
    output cval_t x_o,
    output cval_t y_o,
    output cval_t z_o
);

    cval_t x_reg [STEPS];
    cval_t y_reg [STEPS];
    cval_t z_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        cval_t xp, yp, zp, dx, dy;
        cval_t x_next, y_next, z_next;
        logic  pos;

        if (i == 0)
        begin : g_first
            assign xp = x_i;
            assign yp = y_i;
            assign zp = z_i;
        end
        else
        begin : g_rest
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
        end

        assign dx  = yp >>> i;
        assign dy  = xp >>> i;
        // Rotation steers by the residual angle, vectoring by the sign of y.
        assign pos = VECTOR ? !yp[CW-1] : !zp[CW-1];

        always_comb
        begin
            if (VECTOR)
            begin
                x_next = pos ? xp + dx : xp - dx;
                y_next = pos ? yp - dy : yp + dy;
                z_next = pos ? zp + atan_q30(i) : zp - atan_q30(i);
            end
            else
            begin
                x_next = pos ? xp - dx : xp + dx;
                y_next = pos ? yp + dy : yp - dy;
                z_next = pos ? zp - atan_q30(i) : zp + atan_q30(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign x_o = x_reg[STEPS-1];
    assign y_o = y_reg[STEPS-1];
    assign z_o = z_reg[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/hd_isqrt.sv =====
// Pipelined floor square root by the shift-and-subtract digit recurrence,
// one root bit per register stage. Depends on hd_pkg.
`default_nettype none

module hd_isqrt
    import hd_pkg::*;
(
    input  wire                    clk,
    input  wire                    en,
    input  wire [SQRT_W-1:0]       v_i,
    output logic [SQRT_STEPS-1:0]  root_o
);

    logic [SQRT_W-1:0]     v_reg    [SQRT_STEPS];
    logic [32:0]           rem_reg  [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] root_reg [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_step
        logic [SQRT_W-1:0]     vp;
        logic [32:0]           rp;
        logic [SQRT_STEPS-1:0] qp;
        logic [34:0]           acc, trial;
        logic                  ge;

        if (i == 0)
        begin : g_first
            assign vp = v_i;
            assign rp = '0;
            assign qp = '0;
        end
        else
        begin : g_rest
            assign vp = v_reg[i-1];
            assign rp = rem_reg[i-1];
            assign qp = root_reg[i-1];
        end

        // Bring down the next two radicand bits and try subtracting 4q+1.
        assign acc   = {rp, vp[SQRT_W-1-2*i -: 2]};
        assign trial = {2'b00, qp, 2'b01};
        assign ge    = acc >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i]    <= vp;
                rem_reg[i]  <= ge ? 33'(acc - trial) : 33'(acc);
                root_reg[i] <= {qp[SQRT_STEPS-2:0], ge};
            end
        end
    end

    assign root_o = root_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/haversine_distance.sv =====
// Haversine great-circle distance: a valid/ready pipeline from a position pair
// to a distance in metres. Depends on hd_pkg, hd_if, hd_cordic and hd_isqrt.
//
// Usage. Position pairs arrive on the pairs channel, one word per pair, with
// latitudes and longitudes in units of 1e-7 degree. Each pair gives exactly
// one word on the result channel: the distance rounded to whole metres, in
// the same order. The earth radius is written through radius_we/radius_wdata
// while the pipeline is empty; it resets to 6378137 m.
//
// Timing. The datapath is one long pipeline: input register, two stages of
// angle conversion, CORDIC_STEPS sine/cosine stages, three stages that form
// the haversine term, 31 square-root stages, CORDIC_STEPS arctangent stages
// and two stages of radius scaling, with CORDIC_STEPS capped at MAX_STEPS.
// A new pair can enter in every cycle while the result channel does not stall.
//
// Reset clears every valid bit, so no stale word appears afterward. When the
// receiver holds ready low while a distance is waiting, the whole pipeline
// freezes and pairs.ready drops in the same cycle; nothing is lost or doubled,
// and empty stages do not close up.
`default_nettype none

module haversine_distance
    import hd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire        clk,
    input  wire        rst_n,
    hd_pair_if.sink    pairs,
    hd_dist_if.source  result,
    input  wire        radius_we,
    input  wire [22:0] radius_wdata
);

    localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int LAT   = 8 + 2 * NSTEP + SQRT_STEPS;

    logic [LAT-1:0] vld_reg;
    logic [22:0]    radius_reg;
    logic           adv;

    // The pipeline moves when its last stage is empty or being drained.
    assign adv          = !vld_reg[LAT-1] || result.ready;
    assign pairs.ready  = adv;
    assign result.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[LAT-2:0], pairs.valid};
            if (radius_we)
                radius_reg <= radius_wdata;
        end
    end

    // Stage 1: clamp latitudes, form the differences and wrap the longitude
    // difference into one half turn on either side.
    logic signed [30:0] la_c, lb_c;
    logic signed [33:0] dlon_raw, dlon_w;
    logic signed [31:0] ang_next [4];
    logic signed [31:0] ang_reg  [4];

    always_comb
    begin
        la_c = pairs.lat_a;
        if (pairs.lat_a > LAT_LIMIT)
            la_c = LAT_LIMIT;
        else if (pairs.lat_a < -LAT_LIMIT)
            la_c = -LAT_LIMIT;

        lb_c = pairs.lat_b;
        if (pairs.lat_b > LAT_LIMIT)
            lb_c = LAT_LIMIT;
        else if (pairs.lat_b < -LAT_LIMIT)
            lb_c = -LAT_LIMIT;

        dlon_raw = 34'(pairs.lon_b) - 34'(pairs.lon_a);
        dlon_w   = dlon_raw;
        if (dlon_raw >= HALF_TURN)
            dlon_w = dlon_raw - FULL_TURN;
        else if (dlon_raw < -HALF_TURN)
            dlon_w = dlon_raw + FULL_TURN;

        ang_next[0] = 32'(lb_c) - 32'(la_c);
        ang_next[1] = 32'(dlon_w);
        ang_next[2] = 32'(la_c) <<< 1;
        ang_next[3] = 32'(lb_c) <<< 1;
    end

    // Stages 2 and 3: scale each angle to radians by a magnitude multiply,
    // then round and restore the sign.
    logic [63:0] prod_reg [4];
    logic        neg_reg  [4];
    cval_t       rad_reg  [4];
    cval_t       sin_w    [4];
    cval_t       cos_w    [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic [31:0] mag;
        logic [31:0] rnd;

        assign mag = ang_reg[k][31] ? 32'(-ang_reg[k]) : 32'(ang_reg[k]);
        assign rnd = 32'((prod_reg[k] + 64'h8000_0000) >> 32);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ang_reg[k]  <= ang_next[k];
                prod_reg[k] <= 64'(mag) * 64'(CONV);
                neg_reg[k]  <= ang_reg[k][31];
                rad_reg[k]  <= neg_reg[k] ? -cval_t'({2'b00, rnd}) : cval_t'({2'b00, rnd});
            end
        end

        hd_cordic #(.STEPS(NSTEP), .VECTOR(1'b0)) u_rot (
            .clk (clk),
            .en  (adv),
            .x_i (GAIN_INV),
            .y_i ('0),
            .z_i (rad_reg[k]),
            .x_o (cos_w[k]),
            .y_o (sin_w[k]),
            .z_o ()
        );
    end

    // Haversine term over three stages: squares and the cosine product,
    // then rounding and the second product, then the clamped sum.
    logic [31:0] m1, m2, uca, ucb;
    logic [63:0] sqp1_reg, sqp2_reg, ccp_reg;
    logic [35:0] sq1_next, sq1_reg;
    logic [33:0] cc_next, sq2_next;
    logic [67:0] tp_reg;
    logic [39:0] t_next;
    logic [40:0] sum_next;
    logic [31:0] a_next;
    logic [SQRT_W-1:0] va_reg, vb_reg;

    assign m1  = sin_w[0][CW-1] ? 32'(-sin_w[0]) : 32'(sin_w[0]);
    assign m2  = sin_w[1][CW-1] ? 32'(-sin_w[1]) : 32'(sin_w[1]);
    // A cosine slightly below zero near a pole counts as zero.
    assign uca = (cos_w[2] > 0) ? 32'(cos_w[2]) : '0;
    assign ucb = (cos_w[3] > 0) ? 32'(cos_w[3]) : '0;

    assign sq1_next = 36'((sqp1_reg + 64'h0800_0000) >> 28);
    assign cc_next  = 34'((ccp_reg + 64'h2000_0000) >> 30);
    assign sq2_next = 34'((sqp2_reg + 64'h2000_0000) >> 30);
    assign t_next   = 40'((tp_reg + 68'h0800_0000) >> 28);
    assign sum_next = 41'(sq1_reg) + 41'(t_next);
    assign a_next   = (sum_next > 41'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum_next[31:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqp1_reg <= 64'(m1) * 64'(m1);
            sqp2_reg <= 64'(m2) * 64'(m2);
            ccp_reg  <= 64'(uca) * 64'(ucb);
            sq1_reg  <= sq1_next;
            tp_reg   <= 68'(cc_next) * 68'(sq2_next);
            va_reg   <= {2'b00, a_next, 28'b0};
            vb_reg   <= {1'b0, 33'h1_0000_0000 - 33'(a_next), 28'b0};
        end
    end

    // Square roots of a and 1-a, both in Q2.30.
    logic [SQRT_STEPS-1:0] ra, rb;

    hd_isqrt u_sqrt_a (
        .clk    (clk),
        .en     (adv),
        .v_i    (va_reg),
        .root_o (ra)
    );

    hd_isqrt u_sqrt_b (
        .clk    (clk),
        .en     (adv),
        .v_i    (vb_reg),
        .root_o (rb)
    );

    // Half the central angle by vectoring (x = sqrt(1-a), y = sqrt(a)).
    cval_t half_ang;

    hd_cordic #(.STEPS(NSTEP), .VECTOR(1'b1)) u_vec (
        .clk (clk),
        .en  (adv),
        .x_i (cval_t'({3'b000, rb})),
        .y_i (cval_t'({3'b000, ra})),
        .z_i ('0),
        .x_o (),
        .y_o (),
        .z_o (half_ang)
    );

    // Scale by the radius; the factor two folds into the final shift.
    logic [30:0] z_pos;
    logic [53:0] rz_reg;
    logic [24:0] dist_reg;

    assign z_pos = half_ang[CW-1] ? '0 : half_ang[30:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rz_reg   <= 54'(radius_reg) * 54'(z_pos);
            dist_reg <= 25'((55'(rz_reg) + 55'h1000_0000) >> 29);
        end
    end

    assign result.distance_m = dist_reg;

endmodule

`default_nettype wire

// ===== rtl/hd_checker.sv =====
// Port-level assertions for the haversine distance block, bound to its top
// level. Depends on haversine_distance and its channel interfaces.
`default_nettype none

module hd_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [24:0] out_dist
);

    // A waiting word stays offered and unchanged until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_dist))
        else $error("result word changed or vanished while stalled");

    // Input ready follows the drain condition of the last stage exactly.
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output stall");

    // During reset no word is shown.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // A freshly stalled pipeline refuses input in the same cycle.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");

endmodule

bind haversine_distance hd_checker u_hd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pairs.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_dist  (result.distance_m)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for haversine_distance: drives position pairs, checks distances.
// It predicts each distance with its own fixed-point haversine model.
// Depends on hd_pkg, hd_if and the haversine_distance RTL.
`default_nettype none

module tb_top
    import hd_pkg::*;
();

    // The block runs with its default number of CORDIC steps. Any step count
    // beyond forty behaves like forty.
    localparam int STEPS     = (CORDIC_STEPS_DEF > 40) ? 40 : CORDIC_STEPS_DEF;
    localparam int LATENCY   = 2 * CORDIC_STEPS_DEF + 39;
    localparam longint unsigned RAD_SCALE =
        (64'h6487ED5110B4611A + 64'd900000000) / 64'd1800000000;
    localparam longint GAIN_Q30 = 652032874;
    localparam longint POLE     = 900000000;
    localparam longint TURN     = 64'sd3600000000;
    localparam longint HALF     = 1800000000;

    // A position pair as it travels on the input channel.
    typedef struct packed {
        logic signed [30:0] lat_a;
        logic signed [31:0] lon_a;
        logic signed [30:0] lat_b;
        logic signed [31:0] lon_b;
    } pair_t;

    logic        clk;
    logic        rst_n;
    logic        radius_we;
    logic [22:0] radius_wdata;

    hd_pair_if pairs_ch ();
    hd_dist_if dist_ch ();

    haversine_distance dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pairs        (pairs_ch),
        .result       (dist_ch),
        .radius_we    (radius_we),
        .radius_wdata (radius_wdata)
    );

    always #4 clk = ~clk;

    // Arctangent of 2^-i in Q2.30. Steps from 31 on add nothing.
    longint atan_step [40];
    initial
    begin
        atan_step = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                      2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1,
                      0, 0, 0, 0, 0, 0, 0, 0, 0};
    end

    // Radius that the block holds now; changed only while nothing is in flight.
    logic [22:0] radius_now = RADIUS_RESET;

    pair_t       pending_pairs [$];
    logic [24:0] distances_due [$];
    int          mismatches = 0;

    // Both the sender and the receiver insert random idle bursts until the
    // final phase, where they run flat out.
    bit quiet = 0;
    // The receiver starts a long hold-off each time this count moves on.
    int hold_req = 0;

    // Converts 1e-7 degree to Q2.30 radians of half the angle, rounding the
    // magnitude so that the result is symmetric about zero.
    function automatic longint to_radians(input longint deg);
        longint unsigned mag;
        longint          r;
        mag = (deg < 0) ? longint'(-deg) : deg;
        r   = longint'((mag * RAD_SCALE + 64'h80000000) >> 32);
        return (deg < 0) ? -r : r;
    endfunction

    // Rotation-mode CORDIC; the >>> on a signed longint floors like the block.
    function automatic void sine_cosine(input longint ang, output longint s,
                                        output longint c);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0)
            begin
                x -= dx; y += dy; ang -= atan_step[i];
            end
            else
            begin
                x += dx; y -= dy; ang += atan_step[i];
            end
        end
        s = y;
        c = x;
    endfunction

    // Floor square root by the digit recurrence.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clamp_to_pole(input longint v);
        if (v > POLE)
            return POLE;
        if (v < -POLE)
            return -POLE;
        return v;
    endfunction

    // Expected distance in metres for one pair at the current radius.
    function automatic logic [24:0] haversine_metres(input pair_t p);
        longint          la;
        longint          lb;
        longint          dlon;
        longint          s1;
        longint          c1;
        longint          s2;
        longint          c2;
        longint          ca;
        longint          cb;
        longint          unused_s;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint unsigned m1;
        longint unsigned m2;
        longint unsigned uca;
        longint unsigned ucb;
        longint unsigned sq1;
        longint unsigned cc;
        longint unsigned sq2;
        longint unsigned hav;
        longint unsigned metres;
        la   = clamp_to_pole(longint'(p.lat_a));
        lb   = clamp_to_pole(longint'(p.lat_b));
        dlon = (longint'(p.lon_b) - longint'(p.lon_a)) % TURN;
        if (dlon >= HALF)
            dlon -= TURN;
        if (dlon < -HALF)
            dlon += TURN;

        sine_cosine(to_radians(lb - la), s1, c1);
        sine_cosine(to_radians(dlon), s2, c2);
        sine_cosine(to_radians(2 * la), unused_s, ca);
        sine_cosine(to_radians(2 * lb), unused_s, cb);

        m1  = (s1 < 0) ? longint'(-s1) : s1;
        m2  = (s2 < 0) ? longint'(-s2) : s2;
        // A cosine that CORDIC drives slightly negative near a pole is zero.
        uca = (ca > 0) ? ca : 0;
        ucb = (cb > 0) ? cb : 0;

        sq1 = (m1 * m1 + (64'd1 << 27)) >> 28;
        cc  = (uca * ucb + (64'd1 << 29)) >> 30;
        sq2 = (m2 * m2 + (64'd1 << 29)) >> 30;
        hav = sq1 + ((cc * sq2 + (64'd1 << 27)) >> 28);
        if (hav > 64'hFFFFFFFF)
            hav = 64'hFFFFFFFF;

        // Half the central angle by vectoring CORDIC on (sqrt(1-a), sqrt(a)).
        x = floor_sqrt((64'h100000000 - hav) << 28);
        y = floor_sqrt(hav << 28);
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_step[i];
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step[i];
            end
        end
        if (z < 0)
            z = 0;

        metres = (64'(radius_now) * 64'd2 * 64'(z) + (64'd1 << 29)) >> 30;
        return metres[24:0];
    endfunction

    // Sender. A word is loaded only when the channel is empty or the last word
    // was just taken, so valid never drops while the block stalls the input.
    // The expected distance is worked out at the edge that accepts the word.
    pair_t on_offer;
    int    send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_ch.valid <= 1'b0;
            pairs_ch.lat_a <= '0;
            pairs_ch.lon_a <= '0;
            pairs_ch.lat_b <= '0;
            pairs_ch.lon_b <= '0;
            send_gap = 0;
        end
        else
        begin
            if (pairs_ch.valid && pairs_ch.ready)
                distances_due.push_back(haversine_metres(on_offer));
            if (!pairs_ch.valid || pairs_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pairs_ch.valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 8) - 1;
                    pairs_ch.valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    on_offer = pending_pairs.pop_front();
                    pairs_ch.valid <= 1'b1;
                    pairs_ch.lat_a <= on_offer.lat_a;
                    pairs_ch.lon_a <= on_offer.lon_a;
                    pairs_ch.lat_b <= on_offer.lat_b;
                    pairs_ch.lon_b <= on_offer.lon_b;
                end
                else
                    pairs_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver. Each distance word is compared with the oldest expectation.
    // Ready falls in random bursts, and on request it stays low long enough
    // for the whole pipeline to fill and push back on the input.
    int hold_seen;
    int hold_left;
    int sink_gap;

    always @(posedge clk or negedge rst_n)
    begin
        logic [24:0] want;
        if (!rst_n)
        begin
            dist_ch.ready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
            sink_gap  = 0;
        end
        else
        begin
            if (dist_ch.valid && dist_ch.ready)
            begin
                if (distances_due.size() == 0)
                begin
                    $display("%0t: unexpected distance word, expected none, got %0d",
                             $time, dist_ch.distance_m);
                    mismatches++;
                end
                else
                begin
                    want = distances_due.pop_front();
                    if (dist_ch.distance_m !== want)
                    begin
                        $display("%0t: distance_m expected %0d, got %0d",
                                 $time, want, dist_ch.distance_m);
                        mismatches++;
                    end
                end
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = 4 * LATENCY;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dist_ch.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                dist_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(1, 8) - 1;
                dist_ch.ready <= 1'b0;
            end
            else
                dist_ch.ready <= 1'b1;
        end
    end

    function automatic void queue_pair(input longint la, input longint oa,
                                       input longint lb, input longint ob);
        pair_t p;
        p.lat_a = la[30:0];
        p.lon_a = oa[31:0];
        p.lat_b = lb[30:0];
        p.lon_b = ob[31:0];
        pending_pairs.push_back(p);
    endfunction

    function automatic longint any_lat();
        return longint'($urandom_range(0, 1800000000)) - POLE;
    endfunction

    function automatic longint any_lon();
        return longint'($urandom_range(0, 32'd3600000000)) - HALF;
    endfunction

    // Mostly real positions, some raw full-width words (latitudes past the
    // poles, longitudes past the date line) and some near-coincident or
    // near-antipodal pairs where the haversine term sits at its ends.
    task automatic queue_random(input int n);
        longint la;
        longint oa;
        int     kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 19);
            la = any_lat();
            oa = any_lon();
            if (kind < 12)
                queue_pair(la, oa, any_lat(), any_lon());
            else if (kind < 16)
                queue_pair(longint'($urandom), longint'($urandom),
                           longint'($urandom), longint'($urandom));
            else if (kind < 18)
                queue_pair(la, oa, la + $urandom_range(0, 2000) - 1000,
                           oa + $urandom_range(0, 2000) - 1000);
            else
                queue_pair(la, oa, -la + $urandom_range(0, 200) - 100,
                           oa + HALF + $urandom_range(0, 200) - 100);
        end
    endtask

    // Waits at falling edges until no pair is pending or on offer and every
    // expected distance has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pairs.size() > 0 || pairs_ch.valid || distances_due.size() > 0);
    endtask

    task automatic write_radius(input logic [22:0] value);
        @(posedge clk);
        radius_we    <= 1'b1;
        radius_wdata <= value;
        @(posedge clk);
        radius_we    <= 1'b0;
        radius_now = value;
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        radius_we    = 1'b0;
        radius_wdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs at the reset radius: zero distance, half a turn on
        // the equator, the poles, latitudes past the poles that saturate,
        // longitude differences that wrap, and the extreme field codes.
        queue_pair(0, 0, 0, 0);
        queue_pair(123456789, -987654321, 123456789, -987654321);
        queue_pair(0, 0, 0, 1800000000);
        queue_pair(0, -1800000000, 0, 1800000000);
        queue_pair(900000000, 0, -900000000, 0);
        queue_pair(900000000, 0, 900000000, 1800000000);
        queue_pair(-900000000, 123, -900000000, -456);
        queue_pair(1073741823, 0, -1073741824, 0);
        queue_pair(1073741823, 2147483647, 900000001, -2147483648);
        queue_pair(0, 2147483647, 0, -2147483648);
        queue_pair(0, -2147483648, 0, 2147483647);
        queue_pair(0, 1700000000, 0, -1700000000);
        queue_pair(0, -1800000000, 0, 0);
        queue_pair(0, 0, 0, 1);
        queue_pair(0, 0, 1, 0);
        queue_pair(-1073741824, -2147483648, -1073741824, 2147483647);
        queue_pair(450000000, 100000000, -450000000, -1700000000);
        queue_pair(899999999, 0, -899999999, 1799999999);
        queue_pair(515000000, -1200000, 407000000, -740000000);
        queue_pair(-338000000, 1512000000, 517000000, -1000000);
        wait_drained();

        // Radius at its low end, random traffic.
        write_radius(23'd6300000);
        queue_random(170);
        wait_drained();

        // Radius at its high end. The receiver holds off while the sender keeps
        // offering, so the pipeline fills and input ready must drop.
        write_radius(23'd6400000);
        queue_random(170);
        @(negedge clk);
        hold_req++;
        wait_drained();

        // Largest radius the register holds, then the smallest.
        write_radius(23'h7FFFFF);
        queue_random(80);
        wait_drained();
        write_radius(23'd0);
        queue_random(20);
        wait_drained();

        write_radius(23'(6300000 + $urandom_range(0, 100000)));
        queue_random(170);
        wait_drained();

        // Last phase: no idling on either side, back at the standard radius.
        write_radius(RADIUS_RESET);
        @(negedge clk);
        quiet = 1'b1;
        queue_random(220);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0)
            $display("haversine_distance: match");
        else
            $display("haversine_distance: mismatch");
        $finish;
    end

    initial
    begin
        #(8 * 2000000);
        $display("haversine_distance: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== haversine_distance.f =====
rtl/hd_pkg.sv
rtl/hd_if.sv
rtl/hd_cordic.sv
rtl/hd_isqrt.sv
rtl/haversine_distance.sv
rtl/hd_checker.sv
tb/sv/tb_top.sv
